// ===== sv/rrnr_pkg.sv =====
`timescale 1ns / 1ps

package rrnr_pkg;

  // Default sizes, handed down from the top level.
  localparam int unsigned RING_DEPTH_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Command codes on cmd_i.
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_TRIM  = 2'd1;
  localparam logic [1:0] CMD_RETRY = 2'd2;

  // Request ID words.
  localparam logic [31:0] ID_RETRY = 32'h5472_6571;
  localparam logic [31:0] ID_FAST  = 32'h5466_7374;

  // Sign bit of a 16-bit sequence distance.
  localparam logic [15:0] SEQ_SIGN = 16'h8000;

  // Result kinds.
  localparam logic KIND_NAK    = 1'b0;
  localparam logic KIND_RESEND = 1'b1;

  // Operation carried from the front end to the back end.
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_TRIM,
    OP_RETRY,
    OP_FAST
  } op_e;

  // One queued command. The stamp is the expiry time for a push and the
  // current time for a trim.
  typedef struct packed {
    op_e         op;
    logic [31:0] handle;
    logic [15:0] seq;
    logic [47:0] stamp;
    logic [15:0] rs;
    logic [15:0] re;
  } cmd_entry_t;

  // One ring entry as it is kept in the ring memory.
  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] seq;
    logic [47:0] expiry;
  } ring_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_TRIM_RD,
    ST_TRIM_CHK,
    ST_RQ_FIRST,
    ST_RQ_NEWEST,
    ST_RQ_EVAL,
    ST_RQ_CLASS,
    ST_RESEND
  } state_e;

endpackage

// ===== sv/rrnr_ram.sv =====
`timescale 1ns / 1ps

module rrnr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rrnr_queue.sv =====
`timescale 1ns / 1ps

module rrnr_queue
  import rrnr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output cmd_entry_t entry_o,
  output logic       empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_entry_t        slot_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/rrnr_front.sv =====
`timescale 1ns / 1ps

module rrnr_front
  import rrnr_pkg::*;
(
  input  logic        start_i,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] packet_handle_i,
  input  logic [15:0] packet_seq_i,
  input  logic [47:0] expire_time_i,
  input  logic [47:0] time_now_i,
  input  logic [31:0] request_id_i,
  input  logic [15:0] req_start_i,
  input  logic [15:0] req_end_i,
  input  logic        q_full_i,
  output logic        busy_o,
  output logic        q_push_o,
  output cmd_entry_t  q_entry_o
);

  logic keep;

  // Unused commands and requests with an unknown ID are dropped here,
  // so the back end only ever sees work that changes state or answers.
  always_comb begin
    keep           = 1'b0;
    q_entry_o.op     = OP_PUSH;
    q_entry_o.handle = packet_handle_i;
    q_entry_o.seq    = packet_seq_i;
    q_entry_o.stamp  = expire_time_i;
    q_entry_o.rs     = req_start_i;
    q_entry_o.re     = req_end_i;
    case (cmd_i)
      CMD_PUSH: begin
        keep = 1'b1;
      end
      CMD_TRIM: begin
        keep            = 1'b1;
        q_entry_o.op    = OP_TRIM;
        q_entry_o.stamp = time_now_i;
      end
      CMD_RETRY: begin
        if (request_id_i == ID_RETRY) begin
          keep         = 1'b1;
          q_entry_o.op = OP_RETRY;
        end else if (request_id_i == ID_FAST) begin
          keep         = 1'b1;
          q_entry_o.op = OP_FAST;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy_o   = q_full_i;
  assign q_push_o = start_i && !q_full_i && keep;

endmodule

// ===== sv/rrnr_back.sv =====
`timescale 1ns / 1ps

module rrnr_back
  import rrnr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_entry_t  q_entry_i,
  output logic        q_pop_o,
  output logic        res_valid_o,
  output logic        kind_o,
  output logic [15:0] nak_start_o,
  output logic [15:0] nak_end_o,
  output logic [31:0] resend_handle_o,
  output logic        last_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned ENT_W = $bits(ring_entry_t);

  state_e        state_q, state_d;
  cmd_entry_t    cur_q, cur_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]   first_q, first_d, newest_q, newest_d, st_q, st_d;
  logic [PTR_W-1:0] idx_q, idx_d, end_q, end_d;
  logic          pend_q, pend_d, pend_last_q, pend_last_d;
  logic          ovalid_q, ovalid_d, okind_q, okind_d, olast_q, olast_d;
  logic [15:0]   onak_s_q, onak_s_d, onak_e_q, onak_e_d;
  logic [31:0]   ohandle_q, ohandle_d;

  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  ring_entry_t      ram_wdata, ram_rd;
  logic [ENT_W-1:0] ram_rdata;

  logic [CNT_W-1:0] cnt_m1;
  logic [15:0]      cnt_m1_w;
  logic             s_in, e_in, all_miss, have;
  logic [15:0]      si, ei, si_adj, ei_adj, ei_sat;
  logic [15:0]      nak_s, nak_e;
  logic [15:0]      st_gap;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Physical slot of the entry idx places after the oldest one.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] idx);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (PTR_W + 1)'(RING_DEPTH)) begin
      sum = sum - (PTR_W + 1)'(RING_DEPTH);
    end
    slot = sum[PTR_W-1:0];
  endfunction

  // Membership in an inclusive window that may wrap past zero.
  function automatic logic in_window(input logic [15:0] v, input logic [15:0] s,
                                     input logic [15:0] e);
    if (s <= e) begin
      in_window = (v >= s) && (v <= e);
    end else begin
      in_window = (v >= s) || (v <= e);
    end
  endfunction

  rrnr_ram #(
    .WIDTH(ENT_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_rd    = ring_entry_t'(ram_rdata);
  assign ram_wdata = '{handle: cur_q.handle, seq: cur_q.seq, expiry: cur_q.stamp};

  assign cnt_m1   = count_q - CNT_W'(1);
  assign cnt_m1_w = 16'(cnt_m1);
  assign st_gap   = cur_q.rs - first_q;

  // Classification of a request from the registered window ends.
  always_comb begin
    s_in     = in_window(st_q, first_q, newest_q);
    e_in     = in_window(cur_q.re, first_q, newest_q);
    all_miss = !s_in && !e_in;
    si       = st_q - first_q;
    ei       = cur_q.re - first_q;
    si_adj   = s_in ? si : 16'd0;
    ei_adj   = (s_in && !e_in) ? cnt_m1_w : ei;
    ei_sat   = (ei_adj > cnt_m1_w) ? cnt_m1_w : ei_adj;
    have     = !all_miss && (si_adj <= ei_sat);
    if (all_miss) begin
      nak_s = cur_q.rs;
      nak_e = cur_q.re;
    end else if (!s_in) begin
      nak_s = cur_q.rs;
      nak_e = first_q - 16'd1;
    end else begin
      nak_s = newest_q + 16'd1;
      nak_e = cur_q.re;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_entry_i.op)
            OP_PUSH:  state_d = ST_PUSH;
            OP_TRIM:  state_d = ST_TRIM_RD;
            default:  state_d = ST_RQ_FIRST;
          endcase
        end
      end
      ST_PUSH:      state_d = ST_IDLE;
      ST_TRIM_RD:   state_d = (count_q == '0) ? ST_IDLE : ST_TRIM_CHK;
      ST_TRIM_CHK:  state_d = (ram_rd.expiry < cur_q.stamp) ? ST_TRIM_RD : ST_IDLE;
      ST_RQ_FIRST:  state_d = (count_q == '0) ? ST_IDLE : ST_RQ_NEWEST;
      ST_RQ_NEWEST: state_d = ST_RQ_EVAL;
      ST_RQ_EVAL:   state_d = ST_RQ_CLASS;
      ST_RQ_CLASS:  state_d = have ? ST_RESEND : ST_IDLE;
      ST_RESEND:    state_d = (idx_q == end_q) ? ST_IDLE : ST_RESEND;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = tail_q;
    cur_d       = cur_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    first_d     = first_q;
    newest_d    = newest_q;
    st_d        = st_q;
    idx_d       = idx_q;
    end_d       = end_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    ovalid_d    = 1'b0;
    okind_d     = okind_q;
    onak_s_d    = onak_s_q;
    onak_e_d    = onak_e_q;
    ohandle_d   = ohandle_q;
    olast_d     = olast_q;

    // A resend read issued last cycle lands in the output register now.
    if (pend_q) begin
      ovalid_d  = 1'b1;
      okind_d   = KIND_RESEND;
      onak_s_d  = 16'd0;
      onak_e_d  = 16'd0;
      ohandle_d = ram_rd.handle;
      olast_d   = pend_last_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
        end
      end
      ST_PUSH: begin
        ram_we = 1'b1;
        head_d = ptr_inc(head_q);
        if (count_q == CNT_W'(RING_DEPTH)) begin
          tail_d = ptr_inc(tail_q);
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      ST_TRIM_RD: begin
        ram_raddr = tail_q;
      end
      ST_TRIM_CHK: begin
        if (ram_rd.expiry < cur_q.stamp) begin
          tail_d  = ptr_inc(tail_q);
          count_d = count_q - CNT_W'(1);
        end
      end
      ST_RQ_FIRST: begin
        ram_raddr = tail_q;
        if (count_q == '0) begin
          ovalid_d  = 1'b1;
          okind_d   = KIND_NAK;
          onak_s_d  = cur_q.rs;
          onak_e_d  = cur_q.re;
          ohandle_d = 32'd0;
          olast_d   = 1'b1;
        end
      end
      ST_RQ_NEWEST: begin
        ram_raddr = slot(tail_q, cnt_m1[PTR_W-1:0]);
        first_d   = ram_rd.seq;
      end
      ST_RQ_EVAL: begin
        newest_d = ram_rd.seq;
        if (cur_q.op == OP_FAST && (st_gap & SEQ_SIGN) == 16'd0) begin
          st_d = first_q;
        end else begin
          st_d = cur_q.rs;
        end
      end
      ST_RQ_CLASS: begin
        idx_d = si_adj[PTR_W-1:0];
        end_d = ei_sat[PTR_W-1:0];
        if (!(s_in && e_in)) begin
          ovalid_d  = 1'b1;
          okind_d   = KIND_NAK;
          onak_s_d  = nak_s;
          onak_e_d  = nak_e;
          ohandle_d = 32'd0;
          olast_d   = !have;
        end
      end
      ST_RESEND: begin
        ram_raddr   = slot(tail_q, idx_q);
        pend_d      = 1'b1;
        pend_last_d = (idx_q == end_q);
        idx_d       = idx_q + PTR_W'(1);
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    first_q     <= first_d;
    newest_q    <= newest_d;
    st_q        <= st_d;
    idx_q       <= idx_d;
    end_q       <= end_d;
    pend_last_q <= pend_last_d;
    okind_q     <= okind_d;
    onak_s_q    <= onak_s_d;
    onak_e_q    <= onak_e_d;
    ohandle_q   <= ohandle_d;
    olast_q     <= olast_d;
  end

  assign res_valid_o     = ovalid_q;
  assign kind_o          = okind_q;
  assign nak_start_o     = onak_s_q;
  assign nak_end_o       = onak_e_q;
  assign resend_handle_o = ohandle_q;
  assign last_o          = olast_q;

endmodule

// ===== sv/retransmit_ring_nak_resolver.sv =====
`timescale 1ns / 1ps
// A retry gives its NAK result, if any, ahead of its resend results, which stream one per cycle
// from the ring memory port.
// Reset is asynchronous, active low, and empties ring and queue; the receiver cannot stall.

// The block keeps one endpoint's retransmit ring. A front end takes each command
// transfer, drops unused commands and requests with an unknown ID, and places the
// rest into a short command queue. busy is high only while that queue is full,
// so commands can be handed over while the back end is still working.
//
// The back end pops one command at a time and runs it against the ring, which is
// held in a single-port-read RAM with registered read data. A push writes the head
// slot, overwriting the oldest entry when the ring is full. A trim reads the oldest
// expiry, compares it with the current time and drops the entry, repeating until an
// entry has not yet expired or the ring is empty. A retry reads the oldest and the
// newest sequence numbers, works out the NAK subrange for the part of the request
// that is not held, and then streams the stored handles one per cycle.
// The ring memory is never cleared: only entries inside the fill count are read.
module retransmit_ring_nak_resolver
  import rrnr_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] packet_handle_i,
  input  logic [15:0] packet_seq_i,
  input  logic [47:0] expire_time_i,
  input  logic [47:0] time_now_i,
  input  logic [31:0] request_id_i,
  input  logic [15:0] req_start_i,
  input  logic [15:0] req_end_i,
  output logic        res_valid_o,
  output logic        kind_o,
  output logic [15:0] nak_start_o,
  output logic [15:0] nak_end_o,
  output logic [31:0] resend_handle_o,
  output logic        last_o
);

  logic       q_push, q_full, q_pop, q_empty;
  cmd_entry_t q_in, q_out;

  // Front end: command decode and request ID filtering.
  rrnr_front u_front (
    .start_i        (start),
    .cmd_i          (cmd_i),
    .packet_handle_i(packet_handle_i),
    .packet_seq_i   (packet_seq_i),
    .expire_time_i  (expire_time_i),
    .time_now_i     (time_now_i),
    .request_id_i   (request_id_i),
    .req_start_i    (req_start_i),
    .req_end_i      (req_end_i),
    .q_full_i       (q_full),
    .busy_o         (busy),
    .q_push_o       (q_push),
    .q_entry_o      (q_in)
  );

  // Command queue between the two halves.
  rrnr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .entry_o(q_out),
    .empty_o(q_empty)
  );

  // Back end: ring state, the ring memory and the result sequencer.
  rrnr_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_entry_i      (q_out),
    .q_pop_o        (q_pop),
    .res_valid_o    (res_valid_o),
    .kind_o         (kind_o),
    .nak_start_o    (nak_start_o),
    .nak_end_o      (nak_end_o),
    .resend_handle_o(resend_handle_o),
    .last_o         (last_o)
  );

endmodule
